>>> rtl/svf_pkg.sv
// ----------------------------------------------------------------------------
// svf_pkg - shared types and constants for the state variable filter
// Sample width, cutoff table, register map and sequencer states.
// ----------------------------------------------------------------------------
package svf_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int CUTOFF_STEPS = 254;

    localparam int TABLE_ROWS  = 254;
    localparam int LAST_ROW    = ((CUTOFF_STEPS < TABLE_ROWS) ? CUTOFF_STEPS : TABLE_ROWS) - 1;
    localparam int ROW_WIDTH   = $clog2(TABLE_ROWS);
    localparam int COEF_WIDTH  = 15;          // largest factor 28378 fits in 15 bits
    localparam int COEF_SHIFT  = 14;
    localparam int DAMP_WIDTH  = 8;
    localparam int DAMP_SHIFT  = 7;
    localparam int MODE_WIDTH  = 2;
    localparam int CIDX_WIDTH  = 8;

    // one shared multiplier: unsigned factor (zero-extended) times signed sample
    localparam int MUL_A_WIDTH = COEF_WIDTH + 1;
    localparam int PROD_WIDTH  = MUL_A_WIDTH + SAMPLE_WIDTH;

    // register map, index = paddr[3:2]
    localparam int ADDR_WIDTH  = 4;
    localparam int DATA_WIDTH  = 32;
    typedef enum logic [1:0] {
        REG_CUTOFF = 2'd0,
        REG_DAMP   = 2'd1,
        REG_MODE   = 2'd2
    } svf_reg_t;

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_LOW   = 2'd0,
        MODE_HIGH  = 2'd1,
        MODE_BAND  = 2'd2,
        MODE_NOTCH = 2'd3
    } svf_mode_t;

    typedef enum logic [2:0] {
        SVF_IDLE,
        SVF_MUL_LOW,
        SVF_MUL_DAMP,
        SVF_HIGH,
        SVF_MUL_BAND,
        SVF_BAND
    } svf_state_t;

    // Q14 cutoff factors
    localparam logic [COEF_WIDTH-1:0] CUTOFF_TABLE [0:TABLE_ROWS-1] = '{
        15'd43, 15'd44, 15'd45, 15'd46, 15'd48, 15'd49, 15'd50, 15'd52, 15'd53, 15'd54,
        15'd56, 15'd57, 15'd59, 15'd60, 15'd62, 15'd64, 15'd65, 15'd67, 15'd69, 15'd71,
        15'd73, 15'd75, 15'd77, 15'd79, 15'd81, 15'd83, 15'd85, 15'd88, 15'd90, 15'd92,
        15'd95, 15'd97, 15'd100, 15'd103, 15'd105, 15'd108, 15'd111, 15'd114, 15'd117,
        15'd120, 15'd123, 15'd127, 15'd130, 15'd134, 15'd137, 15'd141, 15'd145, 15'd148,
        15'd152, 15'd157, 15'd161, 15'd165, 15'd169, 15'd174, 15'd179, 15'd183, 15'd188,
        15'd193, 15'd199, 15'd204, 15'd209, 15'd215, 15'd221, 15'd227, 15'd233, 15'd239,
        15'd245, 15'd252, 15'd259, 15'd266, 15'd273, 15'd280, 15'd287, 15'd295, 15'd303,
        15'd311, 15'd319, 15'd328, 15'd337, 15'd346, 15'd355, 15'd365, 15'd374, 15'd384,
        15'd395, 15'd405, 15'd416, 15'd427, 15'd439, 15'd450, 15'd462, 15'd475, 15'd488,
        15'd501, 15'd514, 15'd528, 15'd542, 15'd556, 15'd571, 15'd587, 15'd602, 15'd618,
        15'd635, 15'd652, 15'd669, 15'd687, 15'd706, 15'd725, 15'd744, 15'd764, 15'd784,
        15'd805, 15'd827, 15'd849, 15'd872, 15'd895, 15'd919, 15'd944, 15'd969, 15'd995,
        15'd1022, 15'd1049, 15'd1077, 15'd1106, 15'd1135, 15'd1166, 15'd1197, 15'd1229,
        15'd1262, 15'd1296, 15'd1330, 15'd1366, 15'd1403, 15'd1440, 15'd1479, 15'd1518,
        15'd1559, 15'd1600, 15'd1643, 15'd1687, 15'd1732, 15'd1779, 15'd1826, 15'd1875,
        15'd1925, 15'd1977, 15'd2030, 15'd2084, 15'd2140, 15'd2197, 15'd2256, 15'd2316,
        15'd2378, 15'd2441, 15'd2506, 15'd2573, 15'd2642, 15'd2713, 15'd2785, 15'd2860,
        15'd2936, 15'd3014, 15'd3095, 15'd3177, 15'd3262, 15'd3349, 15'd3439, 15'd3530,
        15'd3624, 15'd3721, 15'd3820, 15'd3922, 15'd4027, 15'd4134, 15'd4244, 15'd4357,
        15'd4473, 15'd4592, 15'd4714, 15'd4839, 15'd4968, 15'd5100, 15'd5235, 15'd5374,
        15'd5516, 15'd5663, 15'd5813, 15'd5967, 15'd6124, 15'd6286, 15'd6452, 15'd6623,
        15'd6798, 15'd6977, 15'd7161, 15'd7349, 15'd7542, 15'd7741, 15'd7944, 15'd8152,
        15'd8365, 15'd8584, 15'd8808, 15'd9038, 15'd9274, 15'd9515, 15'd9762, 15'd10015,
        15'd10274, 15'd10539, 15'd10811, 15'd11089, 15'd11373, 15'd11664, 15'd11962,
        15'd12267, 15'd12578, 15'd12897, 15'd13222, 15'd13555, 15'd13895, 15'd14242,
        15'd14596, 15'd14957, 15'd15326, 15'd15702, 15'd16086, 15'd16476, 15'd16874,
        15'd17279, 15'd17691, 15'd18110, 15'd18536, 15'd18969, 15'd19408, 15'd19853,
        15'd20304, 15'd20761, 15'd21223, 15'd21691, 15'd22162, 15'd22638, 15'd23117,
        15'd23599, 15'd24082, 15'd24568, 15'd25053, 15'd25539, 15'd26023, 15'd26504,
        15'd26982, 15'd27454, 15'd27920, 15'd28378
    };

endpackage

>>> rtl/svf_in_if.sv
// ----------------------------------------------------------------------------
// svf_in_if - input sample channel
// Valid/ready request channel carrying one audio sample.
// ----------------------------------------------------------------------------
interface svf_in_if import svf_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

>>> rtl/svf_out_if.sv
// ----------------------------------------------------------------------------
// svf_out_if - output sample channel
// Valid/ready request channel carrying one filtered sample.
// ----------------------------------------------------------------------------
interface svf_out_if import svf_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

>>> rtl/state_variable_filter.sv
// ----------------------------------------------------------------------------
// state_variable_filter - Chamberlin state variable filter
// One signed sample in, one selected response (low/high/band/notch) out.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake       payload
//  -------   ---  --------------  -----------------------------
//  in_ch     in   valid / ready   sample_in  [15:0] signed
//  out_ch    out  valid / ready   sample_out [15:0] signed
//  apb       in   psel/penable    paddr[3:0], pwdata/prdata[31:0]
//
//  Sequence: the result is registered at the end of the BAND step; a new request
//  is accepted only back in IDLE; one 16x16 multiplier (15-bit unsigned factor,
//  zero-extended) is shared by the three products F*band, damping*band and
//  F*high, so the multiply sequence sets the rate.
//  Reset: rst_n clears config, delays, valid flag and sequencer; no clear pass.
//  Stalls: a finished result sits in the output register; the next request is
//  accepted meanwhile and only its last step waits for the output to drain.
//
module state_variable_filter
    import svf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready,
    svf_in_if.sink                in_ch,
    svf_out_if.source             out_ch
);

    // configuration registers
    logic [CIDX_WIDTH-1:0] cutoff_index_reg;
    logic [DAMP_WIDTH-1:0] damping_reg;
    logic [MODE_WIDTH-1:0] filter_mode_reg;

    // sequencer
    svf_state_t state_reg, state_next;

    // datapath
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic        [COEF_WIDTH-1:0]   coef_reg;
    logic signed [SAMPLE_WIDTH-1:0] band_delay_reg;
    logic signed [SAMPLE_WIDTH-1:0] low_delay_reg;
    logic signed [SAMPLE_WIDTH-1:0] low_reg;
    logic signed [SAMPLE_WIDTH-1:0] high_reg;
    logic signed [PROD_WIDTH-1:0]   prod_reg;
    logic signed [SAMPLE_WIDTH-1:0] result_reg;
    logic                           out_valid_reg;

    // sequencer controls
    logic accept;
    logic in_ready;
    logic finish;
    logic sel_damp;
    logic sel_high;

    logic signed [MUL_A_WIDTH-1:0]  mul_a;
    logic signed [SAMPLE_WIDTH-1:0] mul_b;
    logic signed [SAMPLE_WIDTH-1:0] prod_coef;   // asr 14, wrapped
    logic signed [SAMPLE_WIDTH-1:0] prod_damp;   // asr 7, wrapped
    logic signed [SAMPLE_WIDTH-1:0] band_val;
    logic signed [SAMPLE_WIDTH-1:0] sel_val;
    logic        [ROW_WIDTH-1:0]    row;
    logic                           cfg_write;
    logic [1:0]                     reg_idx;

    // ---------------- APB configuration ----------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_index_reg <= '0;
            damping_reg      <= '0;
            filter_mode_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_CUTOFF: cutoff_index_reg <= pwdata[CIDX_WIDTH-1:0];
                REG_DAMP:   damping_reg      <= pwdata[DAMP_WIDTH-1:0];
                REG_MODE:   filter_mode_reg  <= pwdata[MODE_WIDTH-1:0];
                default:    ;   // unmapped: ignored
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CUTOFF: prdata = {{(DATA_WIDTH-CIDX_WIDTH){1'b0}}, cutoff_index_reg};
            REG_DAMP:   prdata = {{(DATA_WIDTH-DAMP_WIDTH){1'b0}}, damping_reg};
            REG_MODE:   prdata = {{(DATA_WIDTH-MODE_WIDTH){1'b0}}, filter_mode_reg};
            default:    prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    // IDLE -> MUL_LOW (F*band) -> MUL_DAMP (low, damp*band) -> HIGH
    //      -> MUL_BAND (F*high) -> BAND (band, delays, result) -> IDLE
    assign accept = in_ch.valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SVF_IDLE:     if (accept) state_next = SVF_MUL_LOW;
            SVF_MUL_LOW:  state_next = SVF_MUL_DAMP;
            SVF_MUL_DAMP: state_next = SVF_HIGH;
            SVF_HIGH:     state_next = SVF_MUL_BAND;
            SVF_MUL_BAND: state_next = SVF_BAND;
            SVF_BAND:     if (finish) state_next = SVF_IDLE;
            default:      state_next = SVF_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        finish   = 1'b0;
        sel_damp = 1'b0;
        sel_high = 1'b0;
        case (state_reg)
            SVF_IDLE:     in_ready = 1'b1;
            SVF_MUL_DAMP: sel_damp = 1'b1;
            SVF_MUL_BAND: sel_high = 1'b1;
            // wait here until the output register has room; keep F*high
            // in the product register while waiting
            SVF_BAND:
            begin
                sel_high = 1'b1;
                finish   = !out_valid_reg || out_ch.ready;
            end
            default:      ;
        endcase
    end

    assign in_ch.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= SVF_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------- shared multiplier ----------------
    assign mul_a = sel_damp
                 ? $signed({{(MUL_A_WIDTH-DAMP_WIDTH){1'b0}}, damping_reg})
                 : $signed({1'b0, coef_reg});
    assign mul_b = sel_high ? high_reg : band_delay_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // shift then wrap is just a bit slice of the product
    assign prod_coef = prod_reg[COEF_SHIFT +: SAMPLE_WIDTH];
    assign prod_damp = prod_reg[DAMP_SHIFT +: SAMPLE_WIDTH];

    // ---------------- datapath ----------------
    // cutoff rows past the table saturate to the last row
    assign row = (cutoff_index_reg > CIDX_WIDTH'(LAST_ROW))
               ? ROW_WIDTH'(LAST_ROW)
               : cutoff_index_reg[ROW_WIDTH-1:0];

    assign band_val = prod_coef + band_delay_reg;

    always_comb
    begin
        case (svf_mode_t'(filter_mode_reg))
            MODE_LOW:   sel_val = low_reg;
            MODE_HIGH:  sel_val = high_reg;
            MODE_BAND:  sel_val = band_val;
            MODE_NOTCH: sel_val = high_reg + low_reg;
            default:    sel_val = low_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= in_ch.sample_in;
            coef_reg   <= CUTOFF_TABLE[row];
        end
        if (state_reg == SVF_MUL_DAMP)
            low_reg <= low_delay_reg + prod_coef;
        if (state_reg == SVF_HIGH)
            high_reg <= sample_reg - low_reg - prod_damp;
        if (finish)
            result_reg <= sel_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_delay_reg <= '0;
            low_delay_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (finish)
            begin
                band_delay_reg <= band_val;
                low_delay_reg  <= low_reg;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = result_reg;

    // ---------------- assertions ----------------
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == SVF_MUL_LOW)
        else $error("accepted request did not start the multiply sequence");

    a_result_from_band: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == SVF_BAND)
        else $error("result appeared outside the final step");

    a_low_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(low_delay_reg) |-> $past(state_reg) == SVF_BAND)
        else $error("low delay changed outside the final step");

    a_band_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(band_delay_reg) |-> $past(finish))
        else $error("band delay changed without a finished request");

endmodule
